// ===== rtl/sscs_pkg.sv =====
// Shared types, constants and the LED row mapping for the swipe column scanner.
// No dependencies; used by every module of the block.
`default_nettype none

package sscs_pkg;

  localparam int unsigned LED_ROWS    = 16;
  localparam int unsigned STORE_BITS  = 16;
  localparam int unsigned COUNT_BITS  = 16;
  localparam int unsigned COL_BITS    = 8;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS = 8;

  // request codes
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_EVENT = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ORIENTATION = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIRROR      = 2'd2;

  localparam logic [COL_BITS-1:0] IMAGE_WIDTH_RST = 8'd64;

  // ceil(2^17 / 3): x * RECIP3 >> 17 equals x / 3 for any 16-bit x
  localparam logic [16:0] RECIP3 = 17'd43691;

  typedef struct packed {
    logic [1:0]            req_type;
    logic                  new_direction;
    logic [COL_BITS-1:0]   column_addr;
    logic [STORE_BITS-1:0] column_bits;
  } in_item_t;

  typedef struct packed {
    logic [STORE_BITS-1:0] led_bits;
    logic                  in_window;
    logic [COL_BITS-1:0]   shown_column;
  } out_item_t;

  // column position of one tick, handed from the tracker to the top level
  typedef struct packed {
    logic                in_window;
    logic [COL_BITS-1:0] shown;
  } col_info_t;

  // row order mapping: orientation 1 keeps rows, 0 reverses over LED_ROWS
  function automatic logic [STORE_BITS-1:0] map_rows(input logic [STORE_BITS-1:0] bits,
                                                     input logic ori);
    logic [STORE_BITS-1:0] res;
    int                    src;
    res = '0;
    for (int j = 0; j < STORE_BITS; j++) begin
      if (j < LED_ROWS) begin
        src = ori ? j : (LED_ROWS - 1 - j);
        if (src >= 0 && src < STORE_BITS) begin
          res[j] = bits[src];
        end
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sscs_colmem.sv =====
// Column bitmap store: one write port, one read port with registered data.
// Depends on sscs_pkg for the entry width.
`default_nettype none

module sscs_colmem #(
  parameter int unsigned MAX_COLUMNS = 256
) (
  input  wire                                     clk,
  input  wire                                     wr_en,
  input  wire  [$clog2(MAX_COLUMNS)-1:0]          wr_addr,
  input  wire  [sscs_pkg::STORE_BITS-1:0]         wr_data,
  input  wire                                     rd_en,
  input  wire  [$clog2(MAX_COLUMNS)-1:0]          rd_addr,
  output logic [sscs_pkg::STORE_BITS-1:0]         rd_data_r
);

  logic [sscs_pkg::STORE_BITS-1:0] mem [MAX_COLUMNS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sscs_tracker.sv =====
// Swipe tracker: tick counter, swipe average and center, direction, and the
// column/window computation for each tick. Depends on sscs_pkg.
`default_nettype none

module sscs_tracker (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              accept,
  input  wire  sscs_pkg::in_item_t         item,
  input  wire  [sscs_pkg::COL_BITS-1:0]    image_width,
  input  wire                              flip,
  output sscs_pkg::col_info_t              col_info
);

  localparam int unsigned CW = sscs_pkg::COUNT_BITS;

  logic [CW-1:0] tick_r, tick_nxt;
  logic [CW-1:0] avg_r, avg_nxt;
  logic [CW-1:0] center_r, center_nxt;
  logic          dir_r, dir_nxt;

  logic [CW-1:0]   tick_inc;
  logic [CW:0]     avg_sum;
  logic [CW-1:0]   avg_new;
  logic [CW+16:0]  center_prod;
  logic            turn;
  logic signed [CW+1:0] col;
  logic            win;
  logic [sscs_pkg::COL_BITS-1:0] d_fwd, d_rev;

  assign tick_inc = (tick_r == {CW{1'b1}}) ? tick_r : tick_r + 1'b1;

  // column = tick - (center - width/2), signed
  assign col = $signed({2'b00, tick_inc}) - $signed({2'b00, center_r})
             + $signed({{(CW+2-sscs_pkg::COL_BITS+1){1'b0}}, image_width[7:1]});
  assign win = !col[CW+1] && (col < $signed({{(CW+2-sscs_pkg::COL_BITS){1'b0}}, image_width}));

  assign d_fwd = col[sscs_pkg::COL_BITS-1:0];
  assign d_rev = image_width - col[sscs_pkg::COL_BITS-1:0] - 1'b1;

  always_comb begin
    col_info.in_window = win;
    col_info.shown     = '0;
    if (win) begin
      col_info.shown = (dir_r ^ flip) ? d_fwd : d_rev;
    end
  end

  // swipe turn: average the length (first sample as is), center = average / 3
  assign turn        = accept && (item.req_type == sscs_pkg::REQ_EVENT)
                    && (item.new_direction != dir_r);
  assign avg_sum     = {1'b0, avg_r} + {1'b0, tick_r};
  assign avg_new     = (avg_r != '0) ? avg_sum[CW:1] : tick_r;
  assign center_prod = avg_new * sscs_pkg::RECIP3;

  always_comb begin
    tick_nxt   = tick_r;
    avg_nxt    = avg_r;
    center_nxt = center_r;
    dir_nxt    = dir_r;
    if (turn) begin
      tick_nxt   = '0;
      avg_nxt    = avg_new;
      center_nxt = center_prod[CW+16:17];
      dir_nxt    = item.new_direction;
    end else if (accept && item.req_type == sscs_pkg::REQ_TICK) begin
      tick_nxt = tick_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r   <= '0;
      avg_r    <= '0;
      center_r <= '0;
      dir_r    <= 1'b0;
    end else begin
      tick_r   <= tick_nxt;
      avg_r    <= avg_nxt;
      center_r <= center_nxt;
      dir_r    <= dir_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/swipe_synced_column_scanner_core.sv =====
// Top level of the swipe-synced column scanner.
// A tick's result passes through stage 1 (store read) and the output register before it is offered.
// Throughput: one item per cycle; stalls only when both pipeline stages hold and the output is stalled.
// Reset (rst_n, synchronous, low): counters, direction and valids cleared, config to its defaults;
// the column store keeps its contents and is undefined until written.
// Depends on sscs_pkg, sscs_tracker and sscs_colmem.
`default_nettype none

module swipe_synced_column_scanner_core #(
  parameter int unsigned MAX_COLUMNS = 256
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // input channel
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  sscs_pkg::in_item_t              in_item,
  // result channel
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output sscs_pkg::out_item_t                   out_item,
  // configuration writes
  input  wire                                   cfg_we,
  input  wire  [sscs_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire  [sscs_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

  localparam int unsigned AW = $clog2(MAX_COLUMNS);

  // configuration registers
  logic [sscs_pkg::COL_BITS-1:0] image_width_r;
  logic                          orientation_r;
  logic                          mirror_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= sscs_pkg::IMAGE_WIDTH_RST;
      orientation_r <= 1'b0;
      mirror_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        sscs_pkg::CFG_IMAGE_WIDTH: image_width_r <= cfg_wdata;
        sscs_pkg::CFG_ORIENTATION: orientation_r <= cfg_wdata[0];
        sscs_pkg::CFG_MIRROR:      mirror_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // pipeline control: stage 1 holds the store read, the output register
  // holds the mapped result. Stage 1 moves on when the output frees up.
  logic                 s1_valid_r, s1_valid_nxt;
  sscs_pkg::col_info_t  s1_info_r;
  logic                 s1_hit_r;
  logic                 out_valid_r;
  sscs_pkg::out_item_t  out_item_r;

  logic out_free;
  logic accept;
  logic tick_acc;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_free;
  assign accept   = in_valid && !in_stall;
  assign tick_acc = accept && (in_item.req_type == sscs_pkg::REQ_TICK);

  // swipe state and column of the current tick
  sscs_pkg::col_info_t col_info;

  sscs_tracker u_tracker (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .item        (in_item),
    .image_width (image_width_r),
    .flip        (orientation_r ^ mirror_r),
    .col_info    (col_info)
  );

  // column store: host writes through the input channel, ticks read it
  logic                          col_hit;
  logic                          wr_hit;
  logic [sscs_pkg::STORE_BITS-1:0] rd_data;

  assign col_hit = {1'b0, col_info.shown} < (sscs_pkg::COL_BITS+1)'(MAX_COLUMNS);
  assign wr_hit  = {1'b0, in_item.column_addr} < (sscs_pkg::COL_BITS+1)'(MAX_COLUMNS);

  sscs_colmem #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_colmem (
    .clk       (clk),
    .wr_en     (accept && in_item.req_type == sscs_pkg::REQ_WRITE && wr_hit),
    .wr_addr   (in_item.column_addr[AW-1:0]),
    .wr_data   (in_item.column_bits),
    .rd_en     (tick_acc && col_hit),
    .rd_addr   (col_info.shown[AW-1:0]),
    .rd_data_r (rd_data)
  );

  // stage 1: column info next to the registered store data
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (tick_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (out_free) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      s1_info_r <= col_info;
      s1_hit_r  <= col_hit && col_info.in_window;
    end
  end

  // output register: row order mapping, zero outside the window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_item_r.led_bits     <= s1_hit_r ? sscs_pkg::map_rows(rd_data, orientation_r) : '0;
      out_item_r.in_window    <= s1_info_r.in_window;
      out_item_r.shown_column <= s1_info_r.shown;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // a full pipeline with a stalled output must push back on the input
  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |-> in_stall)
    else $error("pipeline full but input not stalled");

  // every accepted tick lands in stage 1
  a_tick_loads: assert property (@(posedge clk) disable iff (!rst_n)
    tick_acc |=> s1_valid_r)
    else $error("tick transfer lost before stage 1");

  // outside the window all result fields are zero
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.in_window) |->
      (out_item_r.led_bits == '0 && out_item_r.shown_column == '0))
    else $error("nonzero result outside window");

  // a column shown inside the window lies below the image width
  a_shown_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.in_window) |-> (out_item_r.shown_column < image_width_r))
    else $error("shown column beyond image width");

endmodule

`default_nettype wire

// ===== test/swipe_synced_column_scanner_core_test.sv =====
// Self-checking testbench for swipe_synced_column_scanner_core: directed and random
// swipes, store writes and ticks, with predicted columns checked against every result.
// Depends on sscs_pkg and the RTL of the scanner core.
`timescale 1ns / 100ps

module swipe_synced_column_scanner_core_test;

  // request code the block ignores; it has no name in the package
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 250;    // long receiver hold-off, fills the pipeline
  localparam int PHASE_ITEMS = 115;

  // Column model: tracks swipe timing, config and the column store, and keeps
  // the columns that ticks are due to show, oldest first.
  class scan_column_model;
    logic [15:0]         tick_count;
    logic [15:0]         swipe_avg;
    logic [15:0]         swipe_center;
    logic                swipe_dir;
    logic [7:0]          image_width;
    logic                orientation;
    logic                mirror;
    logic [15:0]         column_store [256];
    sscs_pkg::out_item_t due_columns [$];
    int                  mismatches;

    function new();
      tick_count   = '0;
      swipe_avg    = '0;
      swipe_center = '0;
      swipe_dir    = 1'b0;
      image_width  = sscs_pkg::IMAGE_WIDTH_RST;
      orientation  = 1'b0;
      mirror       = 1'b0;
      mismatches   = 0;
    endfunction

    function void set_register(input logic [sscs_pkg::CFG_IDX_BITS-1:0] idx,
                               input logic [sscs_pkg::CFG_DATA_BITS-1:0] data);
      case (idx)
        sscs_pkg::CFG_IMAGE_WIDTH: image_width = data;
        sscs_pkg::CFG_ORIENTATION: orientation = data[0];
        sscs_pkg::CFG_MIRROR:      mirror      = data[0];
        default: ;
      endcase
    endfunction

    // one tick: bump the counter, locate the column, fetch its LED rows
    function sscs_pkg::out_item_t scan_tick();
      int                  w;
      int                  col;
      int                  tc;
      int                  ctr;
      int                  d;
      logic [15:0]         raw;
      sscs_pkg::out_item_t res;
      if (tick_count != 16'hFFFF) tick_count = tick_count + 16'd1;
      w   = image_width;
      tc  = tick_count;
      ctr = swipe_center;
      col = tc - (ctr - w / 2);
      res = '0;
      if (col >= 0 && col < w) begin
        if (swipe_dir ^ orientation ^ mirror) d = col;
        else d = w - col - 1;
        raw = column_store[d[7:0]];
        res.in_window    = 1'b1;
        res.shown_column = d[7:0];
        // orientation 0 puts row 0 at the far end
        for (int j = 0; j < 16; j++) begin
          res.led_bits[orientation ? j : 15 - j] = raw[j];
        end
      end
      return res;
    endfunction

    function void take_item(input sscs_pkg::in_item_t item);
      logic [16:0] sum;
      case (item.req_type)
        sscs_pkg::REQ_EVENT: begin
          if (item.new_direction != swipe_dir) begin
            sum = {1'b0, swipe_avg} + {1'b0, tick_count};
            if (swipe_avg != 16'd0) swipe_avg = sum[16:1];
            else swipe_avg = tick_count;
            swipe_center = swipe_avg / 16'd3;
            tick_count   = '0;
            swipe_dir    = item.new_direction;
          end
        end
        sscs_pkg::REQ_WRITE: column_store[item.column_addr] = item.column_bits;
        sscs_pkg::REQ_TICK:  due_columns.push_back(scan_tick());
        default: ;
      endcase
    endfunction

    function void check_column(input sscs_pkg::out_item_t got);
      sscs_pkg::out_item_t want;
      if (due_columns.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected column: led=%h win=%0d col=%0d",
                   got.led_bits, got.in_window, got.shown_column);
        mismatches++;
        return;
      end
      want = due_columns.pop_front();
      if (got.led_bits !== want.led_bits || got.in_window !== want.in_window ||
          got.shown_column !== want.shown_column) begin
        if (mismatches < 10)
          $display("column mismatch: exp led=%h win=%0d col=%0d, got led=%h win=%0d col=%0d",
                   want.led_bits, want.in_window, want.shown_column,
                   got.led_bits, got.in_window, got.shown_column);
        mismatches++;
      end
    endfunction
  endclass

  logic                               clk = 1'b0;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_stall;
  sscs_pkg::in_item_t                 in_item;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  sscs_pkg::out_item_t                out_item;
  logic                               cfg_we;
  logic [sscs_pkg::CFG_IDX_BITS-1:0]  cfg_index;
  logic [sscs_pkg::CFG_DATA_BITS-1:0] cfg_wdata;

  // idle rates in percent per cycle, set per phase by the main sequence
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // long hold-off request: main bumps the tag, the receiver process counts it down
  int hold_tag  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  scan_column_model scan_model = new();

  swipe_synced_column_scanner_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: stall decided at the falling edge; a pending long hold wins
  // over the random stall rate.
  always @(negedge clk) begin
    if (hold_tag != hold_seen) begin
      hold_seen = hold_tag;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Result monitor: a transfer happens at a rising edge with valid high, stall low.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) scan_model.check_column(out_item);
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("** swipe_synced_column_scanner_core: FAILED **");
    $finish;
  end

  function automatic sscs_pkg::in_item_t make_item(input logic [1:0] req, input logic dir,
                                                   input logic [7:0] addr,
                                                   input logic [15:0] bits);
    sscs_pkg::in_item_t item;
    item.req_type      = req;
    item.new_direction = dir;
    item.column_addr   = addr;
    item.column_bits   = bits;
    return item;
  endfunction

  // every field but the request code random; the caller gives the request code
  function automatic sscs_pkg::in_item_t random_item(input logic [1:0] req);
    return make_item(req, 1'($urandom_range(1)), 8'($urandom_range(255)),
                     16'($urandom_range(65535)));
  endfunction

  // Offer one item and hold it until the transfer. An idle gap, if any, is
  // inserted first, so valid never drops and rises in the same step.
  task automatic push_item(input sscs_pkg::in_item_t item);
    int gap;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    scan_model.take_item(item);
  endtask

  // stop offering and wait for every due column to come out
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (scan_model.due_columns.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [sscs_pkg::CFG_IDX_BITS-1:0] idx,
                                input logic [sscs_pkg::CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    scan_model.set_register(idx, data);
  endtask

  // Registers change only with the block idle: drained, then an extra wait
  // since events and writes leave nothing to wait for.
  task automatic configure(input logic [7:0] width, input logic ori, input logic mir);
    wait_drained();
    repeat (4) @(posedge clk);
    write_register(sscs_pkg::CFG_IMAGE_WIDTH, width);
    write_register(sscs_pkg::CFG_ORIENTATION, {7'd0, ori});
    write_register(sscs_pkg::CFG_MIRROR, {7'd0, mir});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed swipes (direction flip then a run of ticks with the odd
  // store write), plus write bursts, repeated-direction events and junk requests.
  // Ignored items are not counted.
  task automatic run_random(input int target);
    int   sent;
    int   kind;
    int   n;
    logic dir;
    dir  = scan_model.swipe_dir;
    sent = 0;
    while (sent < target) begin
      kind = $urandom_range(99);
      if (kind < 65) begin
        dir = ~dir;
        push_item(make_item(sscs_pkg::REQ_EVENT, dir, 8'($urandom_range(255)),
                            16'($urandom_range(65535))));
        sent++;
        n = $urandom_range(2, 60);
        repeat (n) begin
          push_item(random_item(($urandom_range(9) == 0) ? sscs_pkg::REQ_WRITE
                                                         : sscs_pkg::REQ_TICK));
          sent++;
        end
      end else if (kind < 80) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          push_item(random_item(sscs_pkg::REQ_WRITE));
          sent++;
        end
      end else if (kind < 92) begin
        // same direction again: no effect, the ticks after it carry on counting
        push_item(make_item(sscs_pkg::REQ_EVENT, dir, 8'($urandom_range(255)),
                            16'($urandom_range(65535))));
        n = $urandom_range(1, 8);
        repeat (n) begin
          push_item(random_item(sscs_pkg::REQ_TICK));
          sent++;
        end
      end else begin
        n = $urandom_range(1, 3);
        repeat (n) push_item(random_item(REQ_UNUSED));
      end
    end
  endtask

  task automatic run_phase(input int send_pct, input int stall_pct, input logic [7:0] width,
                           input logic ori, input logic mir, input bit with_hold,
                           input bit with_pause);
    configure(width, ori, mir);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    if (with_hold) begin
      @(posedge clk);
      hold_tag++;
    end
    if (with_pause) begin
      run_random(PHASE_ITEMS / 2);
      // sender sits out until the pipeline is empty
      wait_drained();
      run_random(PHASE_ITEMS / 2);
    end else begin
      run_random(PHASE_ITEMS);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Load every store column first; no tick may read an unwritten entry.
    for (int a = 0; a < 256; a++) begin
      push_item(make_item(sscs_pkg::REQ_WRITE, 1'($urandom_range(1)), 8'(a),
                          16'($urandom_range(65535))));
    end

    // Directed part, reset config (width 64, orientation 0, mirror 0).
    push_item(make_item(sscs_pkg::REQ_TICK, 1'b1, 8'hFF, 16'hFFFF));
    push_item(make_item(sscs_pkg::REQ_TICK, 1'b0, 8'h00, 16'h0000));
    push_item(make_item(sscs_pkg::REQ_TICK, 1'b0, 8'h00, 16'h0000));
    // same direction as stored: ignored
    push_item(make_item(sscs_pkg::REQ_EVENT, 1'b0, 8'hFF, 16'hFFFF));
    // first flip: average taken as is
    push_item(make_item(sscs_pkg::REQ_EVENT, 1'b1, 8'h00, 16'h0000));
    push_item(make_item(sscs_pkg::REQ_TICK, 1'b0, 8'h00, 16'h0000));
    push_item(make_item(sscs_pkg::REQ_TICK, 1'b1, 8'h00, 16'h0000));
    push_item(make_item(sscs_pkg::REQ_TICK, 1'b0, 8'h00, 16'h0000));
    // store extremes and an alternating pattern
    push_item(make_item(sscs_pkg::REQ_WRITE, 1'b0, 8'hFF, 16'hFFFF));
    push_item(make_item(sscs_pkg::REQ_WRITE, 1'b1, 8'h00, 16'h0000));
    push_item(make_item(sscs_pkg::REQ_WRITE, 1'b0, 8'hAA, 16'h5555));
    push_item(make_item(sscs_pkg::REQ_WRITE, 1'b1, 8'h55, 16'hAAAA));
    // unused request code: no effect, no result
    push_item(make_item(REQ_UNUSED, 1'b1, 8'hFF, 16'hFFFF));
    push_item(make_item(REQ_UNUSED, 1'b0, 8'h00, 16'h0000));
    // second flip: running average
    push_item(make_item(sscs_pkg::REQ_EVENT, 1'b0, 8'h12, 16'h3456));
    repeat (4) push_item(make_item(sscs_pkg::REQ_TICK, 1'b0, 8'h00, 16'h0000));
    push_item(make_item(sscs_pkg::REQ_EVENT, 1'b1, 8'h00, 16'h0000));
    repeat (3) push_item(make_item(sscs_pkg::REQ_TICK, 1'b1, 8'hFF, 16'hFFFF));

    // Random phases over the idle modes and a spread of settings, including
    // the widest image, a one-column image and an empty window.
    run_phase(0, 0, 8'd255, 1'b1, 1'b0, 1'b0, 1'b0);
    run_phase(75, 0, 8'd1, 1'b0, 1'b1, 1'b0, 1'b1);
    run_phase(0, 75, 8'd0, 1'b1, 1'b1, 1'b0, 1'b0);
    run_phase(31, 31, 8'd64, 1'b0, 1'b0, 1'b0, 1'b0);
    run_phase(0, 0, 8'($urandom_range(1, 255)), 1'($urandom_range(1)),
              1'($urandom_range(1)), 1'b1, 1'b0);
    run_phase(75, 0, 8'd200, 1'b1, 1'b1, 1'b0, 1'b0);
    run_phase(0, 75, 8'($urandom_range(1, 255)), 1'($urandom_range(1)),
              1'($urandom_range(1)), 1'b0, 1'b0);
    run_phase(31, 31, 8'd128, 1'b0, 1'b1, 1'b0, 1'b0);

    wait_drained();
    repeat (10) @(posedge clk);
    if (scan_model.mismatches == 0 && scan_model.due_columns.size() == 0) begin
      $display("** swipe_synced_column_scanner_core: PASSED **");
    end else begin
      $display("** swipe_synced_column_scanner_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== swipe_synced_column_scanner_core.f =====
rtl/sscs_pkg.sv
rtl/sscs_colmem.sv
rtl/sscs_tracker.sv
rtl/swipe_synced_column_scanner_core.sv
test/swipe_synced_column_scanner_core_test.sv
